### rtl/assert_macros.svh
// Assertion macros for the bounded list RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BLSI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BLSI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/blsi_pkg.sv
// Package with the sizes, codes and cell control type of the bounded list.
`default_nettype none

package blsi_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int VAL_W  = 32;
  localparam int MODE_W = 3;
  localparam int POS_W  = 6;
  localparam int STAT_W = 2;

  localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RMVAL  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SORT   = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;
  localparam logic [STAT_W-1:0] ST_MISSING = 2'd3;

  localparam logic [2:0] CELL_HOLD = 3'd0;
  localparam logic [2:0] CELL_SRCH = 3'd1;
  localparam logic [2:0] CELL_INS  = 3'd2;
  localparam logic [2:0] CELL_DEL  = 3'd3;
  localparam logic [2:0] CELL_SORT = 3'd4;

  typedef struct packed {
    logic [2:0]              op;
    logic                    phase;
    logic [IDX_W-1:0]        sel;
    logic [CNT_W-1:0]        count;
    logic signed [VAL_W-1:0] val;
  } cell_ctl_t;

endpackage

`default_nettype wire

### rtl/bounded_list_insert_remove_search_sort_top.sv
// Top level of the bounded list: sequencer, cell row and result register.
//
// The block keeps up to DEPTH signed 32-bit entries in a row of cells.
// Input beats carry in_mode, in_position and in_item_value; each beat gives
// exactly one result beat with out_status, out_found_index,
// out_removed_value and out_entry_count.
// A beat is accepted only while the sequencer is idle. The cells first
// compare against the value, then the lowest match is encoded, then the
// operation is applied and the result is registered; the next beat is
// taken only once the sequencer has returned to idle.
// Sort on a list that is not marked sorted runs DEPTH odd-even transposition
// phases through the cell row before its result is registered; on a list
// that is already sorted it completes like any other item.
// A new beat may be accepted while the previous result still waits; the
// sequencer holds before applying the operation until the result register
// is free, so a stalled receiver delays but never drops a result.
// Reset empties the list, clears the sorted flag and drops any pending
// result.
`default_nettype none
`include "assert_macros.svh"

module bounded_list_insert_remove_search_sort_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [blsi_pkg::MODE_W-1:0]         in_mode,
  input  logic [blsi_pkg::POS_W-1:0]          in_position,
  input  logic signed [blsi_pkg::VAL_W-1:0]   in_item_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [blsi_pkg::STAT_W-1:0]         out_status,
  output logic [blsi_pkg::POS_W-1:0]          out_found_index,
  output logic signed [blsi_pkg::VAL_W-1:0]   out_removed_value,
  output logic [blsi_pkg::CNT_W-1:0]          out_entry_count
);
  import blsi_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRCH = 3'd1;
  localparam logic [2:0] S_FIND = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_SORT = 3'd4;

  logic [2:0]              state_r, state_nxt;
  logic [MODE_W-1:0]       mode_r;
  logic [POS_W-1:0]        pos_r;
  logic signed [VAL_W-1:0] val_r;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    sorted_r, sorted_nxt;
  logic                    hit_r;
  logic [IDX_W-1:0]        found_r;
  logic [IDX_W-1:0]        sort_cnt_r, sort_cnt_nxt;

  logic                    out_valid_r;
  logic [STAT_W-1:0]       out_status_r;
  logic [POS_W-1:0]        out_found_r;
  logic signed [VAL_W-1:0] out_removed_r;
  logic [CNT_W-1:0]        out_count_r;

  logic                    accept;
  logic                    go;
  logic                    sort_start;
  logic                    exec_fire;
  logic                    sort_done;
  logic                    res_load;
  logic [STAT_W-1:0]       res_status;
  logic [POS_W-1:0]        res_found;
  logic signed [VAL_W-1:0] res_removed;
  logic                    list_full;

  cell_ctl_t               ctl;
  logic signed [VAL_W-1:0] ent_w [DEPTH];
  logic [DEPTH-1:0]        match_w;
  logic [IDX_W-1:0]        first_idx;
  logic                    any_hit;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [VAL_W-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = ent_w[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = ent_w[g+1];
    end
    blsi_cell u_cell (
      .clk       (clk),
      .cell_idx  (IDX_W'(g)),
      .ctl       (ctl),
      .left_val  (left_w),
      .right_val (right_w),
      .entry_val (ent_w[g]),
      .match     (match_w[g])
    );
  end

  blsi_first u_first (
    .hits      (match_w),
    .first_idx (first_idx),
    .any_hit   (any_hit)
  );

  assign accept     = in_valid && !in_stall;
  assign in_stall   = (state_r != S_IDLE);
  assign go         = !out_valid_r || !out_stall;
  assign list_full  = (count_r == CNT_W'(DEPTH));
  assign sort_start = (mode_r == MODE_SORT) && !sorted_r;
  assign exec_fire  = (state_r == S_EXEC) && go && !sort_start;
  assign sort_done  = (state_r == S_SORT) && go && (sort_cnt_r == IDX_W'(DEPTH - 1));
  assign res_load   = exec_fire || sort_done;

  always_comb begin
    ctl          = '0;
    ctl.count    = count_r;
    ctl.val      = val_r;
    ctl.op       = CELL_HOLD;
    ctl.phase    = sort_cnt_r[0];
    res_status   = ST_OK;
    res_found    = '0;
    res_removed  = '0;
    count_nxt    = count_r;
    sorted_nxt   = sorted_r;
    state_nxt    = state_r;
    sort_cnt_nxt = sort_cnt_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        ctl.op    = CELL_SRCH;
        state_nxt = S_FIND;
      end
      S_FIND: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        case (mode_r)
          MODE_APPEND: begin
            if (list_full) begin
              res_status = ST_FULL;
            end else begin
              ctl.op     = CELL_INS;
              ctl.sel    = IDX_W'(count_r);
              count_nxt  = count_r + CNT_W'(1);
              sorted_nxt = 1'b0;
            end
          end
          MODE_INSERT: begin
            if (list_full) begin
              res_status = ST_FULL;
            end else if (int'(pos_r) > int'(count_r)) begin
              res_status = ST_RANGE;
            end else begin
              ctl.op     = CELL_INS;
              ctl.sel    = IDX_W'(pos_r);
              count_nxt  = count_r + CNT_W'(1);
              sorted_nxt = 1'b0;
            end
          end
          MODE_REMOVE: begin
            if (int'(pos_r) >= int'(count_r)) begin
              res_status = ST_RANGE;
            end else begin
              ctl.op      = CELL_DEL;
              ctl.sel     = IDX_W'(pos_r);
              res_removed = ent_w[IDX_W'(pos_r)];
              count_nxt   = count_r - CNT_W'(1);
            end
          end
          MODE_RMVAL: begin
            if (!hit_r) begin
              res_status = ST_MISSING;
            end else begin
              ctl.op    = CELL_DEL;
              ctl.sel   = found_r;
              res_found = POS_W'(found_r);
              count_nxt = count_r - CNT_W'(1);
            end
          end
          MODE_SEARCH: begin
            if (!hit_r) begin
              res_status = ST_MISSING;
            end else begin
              res_found = POS_W'(found_r);
            end
          end
          default: begin
            res_status = ST_OK;
          end
        endcase
        if (!go) begin
          ctl.op    = CELL_HOLD;
          count_nxt = count_r;
          sorted_nxt = sorted_r;
        end else if (sort_start) begin
          state_nxt    = S_SORT;
          sort_cnt_nxt = '0;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SORT: begin
        ctl.op = CELL_SORT;
        if (sort_done) begin
          sorted_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else if (sort_cnt_r != IDX_W'(DEPTH - 1)) begin
          sort_cnt_nxt = sort_cnt_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sorted_r    <= 1'b0;
      sort_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      sorted_r   <= sorted_nxt;
      sort_cnt_r <= sort_cnt_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      pos_r  <= in_position;
      val_r  <= in_item_value;
    end
    if (state_r == S_FIND) begin
      hit_r   <= any_hit;
      found_r <= first_idx;
    end
    if (res_load) begin
      out_status_r  <= res_status;
      out_found_r   <= res_found;
      out_removed_r <= res_removed;
      out_count_r   <= count_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_found_index   = out_found_r;
  assign out_removed_value = out_removed_r;
  assign out_entry_count   = out_count_r;

  `BLSI_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH),
    "entry count exceeds capacity")
  `BLSI_ASSERT_NXT(a_accept_seq, clk, rst_n, accept, state_r == S_SRCH,
    "accepted beat did not start the compare step")
  `BLSI_ASSERT_IMP(a_fail_zero, clk, rst_n, out_valid_r && (out_status_r != ST_OK),
    (out_found_r == '0) && (out_removed_r == '0),
    "failed operation reports nonzero index or value")
  `BLSI_ASSERT_NXT(a_remove_count, clk, rst_n,
    exec_fire && (mode_r == MODE_REMOVE) && (res_status == ST_OK),
    count_r == $past(count_r) - CNT_W'(1),
    "remove at index did not shorten the list")

endmodule

`default_nettype wire

### rtl/blsi_cell.sv
// One list cell: holds an entry, compares it against a value, and shifts, loads or swaps with its neighbors.
`default_nettype none

module blsi_cell (
  input  logic                              clk,
  input  logic [blsi_pkg::IDX_W-1:0]        cell_idx,
  input  blsi_pkg::cell_ctl_t               ctl,
  input  logic signed [blsi_pkg::VAL_W-1:0] left_val,
  input  logic signed [blsi_pkg::VAL_W-1:0] right_val,
  output logic signed [blsi_pkg::VAL_W-1:0] entry_val,
  output logic                              match
);
  import blsi_pkg::*;

  logic signed [VAL_W-1:0] entry_r, entry_nxt;
  logic                    match_r, match_nxt;
  logic                    in_list, next_in_list;

  assign in_list      = CNT_W'(cell_idx) < ctl.count;
  assign next_in_list = (CNT_W'(cell_idx) + CNT_W'(1)) < ctl.count;

  always_comb begin
    entry_nxt = entry_r;
    match_nxt = match_r;
    case (ctl.op)
      CELL_SRCH: begin
        match_nxt = in_list && (entry_r == ctl.val);
      end
      CELL_INS: begin
        if (cell_idx > ctl.sel) begin
          entry_nxt = left_val;
        end else if (cell_idx == ctl.sel) begin
          entry_nxt = ctl.val;
        end
      end
      CELL_DEL: begin
        if (cell_idx >= ctl.sel) begin
          entry_nxt = right_val;
        end
      end
      CELL_SORT: begin
        if (cell_idx[0] == ctl.phase) begin
          if (next_in_list && (right_val < entry_r)) begin
            entry_nxt = right_val;
          end
        end else if ((cell_idx != '0) && in_list && (entry_r < left_val)) begin
          entry_nxt = left_val;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    match_r <= match_nxt;
  end

  assign entry_val = entry_r;
  assign match     = match_r;

endmodule

`default_nettype wire

### rtl/blsi_first.sv
// Priority encoder that finds the lowest cell reporting a match.
`default_nettype none

module blsi_first (
  input  logic [blsi_pkg::DEPTH-1:0] hits,
  output logic [blsi_pkg::IDX_W-1:0] first_idx,
  output logic                       any_hit
);
  import blsi_pkg::*;

  always_comb begin
    first_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (hits[i]) begin
        first_idx = IDX_W'(i);
      end
    end
  end

  assign any_hit = |hits;

endmodule

`default_nettype wire
